@@ rtl/core/meq_pkg.sv @@
// ----------------------------------------------------------------------------
// meq_pkg
// Shared constants, codes, control structs and helper functions for the
// multiband dynamic state-variable equalizer.
// ----------------------------------------------------------------------------
package meq_pkg;

    localparam int BAND_COUNT     = 8;
    localparam int COEF_FRAC_BITS = 24;
    localparam int STATE_WIDTH    = 40;

    localparam int SW             = STATE_WIDTH;
    localparam int EXT_W          = SW + 3;
    localparam int SIG_FRAC       = 8;
    localparam int COEF_W         = 32;
    localparam int MAG_W          = 48;
    localparam int PROD_W         = 80;
    localparam int COEFS_PER_BAND = 11;
    localparam int COEF_DEPTH     = BAND_COUNT * COEFS_PER_BAND;
    localparam int COEF_AW        = $clog2(COEF_DEPTH);
    localparam int BAND_W         = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int ENV_W          = 31;
    localparam int WET_W          = 17;
    localparam int SMP_W          = 16;
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 16;

    localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};
    localparam logic [WET_W-1:0] WET_ONE = WET_W'(32768);

    localparam logic signed [SW-1:0] SW_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SW_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SW_MAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(SW_MIN);

    // coefficient slots within one band
    localparam logic [3:0] CI_G       = 4'd0;
    localparam logic [3:0] CI_A1      = 4'd1;
    localparam logic [3:0] CI_A2      = 4'd2;
    localparam logic [3:0] CI_M0      = 4'd3;
    localparam logic [3:0] CI_M1      = 4'd4;
    localparam logic [3:0] CI_M2      = 4'd5;
    localparam logic [3:0] CI_DET_G   = 4'd6;
    localparam logic [3:0] CI_DET_A1  = 4'd7;
    localparam logic [3:0] CI_DET_A2  = 4'd8;
    localparam logic [3:0] CI_ATK     = 4'd9;
    localparam logic [3:0] CI_REL     = 4'd10;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_DYN  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MUTE = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SOLO = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TGT  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_STEP = 3'd4;

    typedef enum logic [1:0] {
        REQ_FRAME = 2'd0,
        REQ_COEF  = 2'd1,
        REQ_ENV   = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        STP_D0, STP_D1, STP_D2,
        STP_E0, STP_E1, STP_E2, STP_E3, STP_E4, STP_E5,
        STP_MIX
    } t_step;

    typedef enum logic [2:0] {
        ST_IDLE, ST_BAND, ST_MIX, ST_ENV, ST_DONE
    } t_state;

    typedef struct packed {
        logic              load;
        logic              consume;
        t_step             step;
        logic [BAND_W-1:0] band;
        logic              solo_hit;
        logic              solo_on;
    } t_lane_ctl;

    typedef struct packed {
        logic              clr_peaks;
        logic              peak_upd;
        logic              consume;
        logic [BAND_W-1:0] band;
    } t_env_ctl;

    function automatic logic signed [SW-1:0] sat_sw(input logic signed [EXT_W-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SAT_HI) r = SW_MAX;
        else if (v < SAT_LO) r = SW_MIN;
        else r = v[SW-1:0];
        return r;
    endfunction

    function automatic logic mask_bit(input logic [7:0] m, input logic [BAND_W-1:0] b);
        int unsigned bi;
        bi = b;
        return (bi < 8) && m[bi[2:0]];
    endfunction

    function automatic logic [3:0] step_coef(input t_step s);
        logic [3:0] r;
        case (s)
            STP_D0:  r = CI_DET_A1;
            STP_D1:  r = CI_DET_A2;
            STP_D2:  r = CI_DET_G;
            STP_E0:  r = CI_A1;
            STP_E1:  r = CI_A2;
            STP_E2:  r = CI_G;
            STP_E3:  r = CI_M0;
            STP_E4:  r = CI_M1;
            STP_E5:  r = CI_M2;
            default: r = CI_G;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/meq_in_if.sv @@
// ----------------------------------------------------------------------------
// meq_in_if
// Request channel: frames, coefficient writes and envelope reads.
// ----------------------------------------------------------------------------
interface meq_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  req_type;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic        [2:0]  band_sel;
    logic        [3:0]  coef_sel;
    logic signed [31:0] coef_value;

    modport source (output valid, req_type, left_in, right_in, band_sel, coef_sel,
                    coef_value, input ready);
    modport sink (input valid, req_type, left_in, right_in, band_sel, coef_sel,
                  coef_value, output ready);
endinterface

@@ rtl/core/meq_out_if.sv @@
// ----------------------------------------------------------------------------
// meq_out_if
// Result channel: mixed stereo samples or an envelope readout.
// ----------------------------------------------------------------------------
interface meq_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic        [30:0] envelope_value;

    modport source (output valid, left_out, right_out, envelope_value, input ready);
    modport sink (input valid, left_out, right_out, envelope_value, output ready);
endinterface

@@ rtl/core/meq_mul.sv @@
// ----------------------------------------------------------------------------
// meq_mul
// Two-stage signal-by-coefficient multiplier, rounded half away from zero
// and saturated to the state width.
// ----------------------------------------------------------------------------
module meq_mul (
    input  logic                               i_clk,
    input  logic signed [meq_pkg::SW-1:0]      i_a,
    input  logic signed [meq_pkg::COEF_W-1:0]  i_c,
    input  logic                               i_sh16,
    output logic signed [meq_pkg::SW-1:0]      o_p
);
    import meq_pkg::*;

    logic [SW-1:0]     w_ma;
    logic [MAG_W-1:0]  w_ma_ext;
    logic [COEF_W-1:0] w_mc;
    logic [63:0]       r_lo;
    logic [47:0]       r_hi;
    logic              r_neg;
    logic              r_sh16;
    logic [PROD_W-1:0] w_full;
    logic [PROD_W-1:0] w_rnd;
    logic [PROD_W-1:0] w_m;
    logic              w_ovf;
    logic signed [SW-1:0] w_res;

    // stage 1: magnitudes and partial products
    assign w_ma     = i_a[SW-1] ? (~$unsigned(i_a) + SW'(1)) : $unsigned(i_a);
    assign w_ma_ext = MAG_W'(w_ma);
    assign w_mc     = i_c[COEF_W-1] ? (~$unsigned(i_c) + 32'd1) : $unsigned(i_c);

    always_ff @(posedge i_clk) begin
        r_lo   <= w_ma_ext[31:0] * w_mc;
        r_hi   <= w_ma_ext[MAG_W-1:32] * w_mc;
        r_neg  <= i_a[SW-1] ^ i_c[COEF_W-1];
        r_sh16 <= i_sh16;
    end

    // stage 2: combine, round, scale, saturate
    assign w_rnd  = r_sh16 ? (PROD_W'(1) << 15) : (PROD_W'(1) << (COEF_FRAC_BITS - 1));
    assign w_full = {r_hi, 32'd0} + PROD_W'(r_lo) + w_rnd;
    assign w_m    = r_sh16 ? (w_full >> 16) : (w_full >> COEF_FRAC_BITS);
    assign w_ovf  = |w_m[PROD_W-1:SW-1];

    always_comb begin
        if (r_neg) w_res = w_ovf ? SW_MIN : $signed(~w_m[SW-1:0] + SW'(1));
        else       w_res = w_ovf ? SW_MAX : $signed(w_m[SW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        o_p <= w_res;
    end
endmodule

@@ rtl/core/meq_lane.sv @@
// ----------------------------------------------------------------------------
// meq_lane
// One channel's datapath: EQ and detector integrators per band, one shared
// multiplier, and the final wet/dry mix with 16-bit rounding.
// ----------------------------------------------------------------------------
module meq_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  meq_pkg::t_lane_ctl                i_ctl,
    input  logic signed [meq_pkg::SMP_W-1:0]  i_sample,
    input  logic signed [meq_pkg::COEF_W-1:0] i_coef,
    input  logic signed [meq_pkg::COEF_W-1:0] i_wet_c,
    output logic signed [meq_pkg::SMP_W-1:0]  o_sample,
    output logic        [meq_pkg::SW-1:0]     o_mag
);
    import meq_pkg::*;

    localparam logic signed [EXT_W-1:0] HALF_LSB = EXT_W'(1) <<< (SIG_FRAC - 1);
    localparam logic signed [EXT_W-1:0] SMP_HI   = EXT_W'(32767);
    localparam logic signed [EXT_W-1:0] SMP_LO   = EXT_W'(-32768);

    logic signed [SW-1:0] r_eic1 [BAND_COUNT];
    logic signed [SW-1:0] r_eic2 [BAND_COUNT];
    logic signed [SW-1:0] r_dic1 [BAND_COUNT];
    logic signed [SW-1:0] r_dic2 [BAND_COUNT];
    logic signed [SW-1:0] r_dry, r_x, r_solo, r_v1, r_v2;
    logic signed [EXT_W-1:0] r_acc;

    logic                    w_det;
    logic signed [SW-1:0]    w_ic1, w_ic2, w_in, w_sel, w_a, w_p;
    logic signed [COEF_W-1:0] w_c;
    logic signed [SW-1:0]    w_v2n, w_n1, w_n2, w_mix;
    logic signed [EXT_W-1:0] w_y, w_q;
    logic signed [SMP_W-1:0] w_smp;

    assign w_det = (i_ctl.step == STP_D0) || (i_ctl.step == STP_D1) ||
                   (i_ctl.step == STP_D2);
    assign w_ic1 = w_det ? r_dic1[i_ctl.band] : r_eic1[i_ctl.band];
    assign w_ic2 = w_det ? r_dic2[i_ctl.band] : r_eic2[i_ctl.band];
    assign w_in  = w_det ? r_dry : r_x;
    assign w_sel = i_ctl.solo_on ? r_solo : r_x;

    always_comb begin
        case (i_ctl.step)
            STP_D0, STP_E0:         w_a = w_ic1;
            STP_D1, STP_E1:         w_a = sat_sw(EXT_W'(w_in) - EXT_W'(w_ic2));
            STP_D2, STP_E2, STP_E4: w_a = r_v1;
            STP_E3:                 w_a = r_x;
            STP_E5:                 w_a = r_v2;
            STP_MIX:                w_a = sat_sw(EXT_W'(w_sel) - EXT_W'(r_dry));
            default:                w_a = '0;
        endcase
    end

    assign w_c = (i_ctl.step == STP_MIX) ? i_wet_c : i_coef;

    meq_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_c    (w_c),
        .i_sh16 (i_ctl.step == STP_MIX),
        .o_p    (w_p)
    );

    // integrator updates: ic = 2*v - ic
    assign w_v2n = sat_sw(EXT_W'(w_ic2) + EXT_W'(w_p));
    assign w_n1  = sat_sw((EXT_W'(r_v1) <<< 1) - EXT_W'(w_ic1));
    assign w_n2  = sat_sw((EXT_W'(w_v2n) <<< 1) - EXT_W'(w_ic2));

    // mix, then round half up to the sample grid and saturate
    assign w_mix = sat_sw(EXT_W'(r_dry) + EXT_W'(w_p));
    assign w_y   = EXT_W'(w_mix) + HALF_LSB;
    assign w_q   = w_y >>> SIG_FRAC;

    always_comb begin
        if (w_q > SMP_HI) w_smp = 16'sh7FFF;
        else if (w_q < SMP_LO) w_smp = 16'sh8000;
        else w_smp = w_q[SMP_W-1:0];
    end

    assign o_mag = r_v1[SW-1] ? (~$unsigned(r_v1) + SW'(1)) : $unsigned(r_v1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BAND_COUNT; i++) begin
                r_eic1[i] <= '0;
                r_eic2[i] <= '0;
                r_dic1[i] <= '0;
                r_dic2[i] <= '0;
            end
        end else if (i_ctl.consume) begin
            case (i_ctl.step)
                STP_D2: begin
                    r_dic1[i_ctl.band] <= w_n1;
                    r_dic2[i_ctl.band] <= w_n2;
                end
                STP_E2: begin
                    r_eic1[i_ctl.band] <= w_n1;
                    r_eic2[i_ctl.band] <= w_n2;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dry  <= SW'(i_sample) <<< SIG_FRAC;
            r_x    <= SW'(i_sample) <<< SIG_FRAC;
            r_solo <= SW'(i_sample) <<< SIG_FRAC;
        end
        if (i_ctl.consume) begin
            case (i_ctl.step)
                STP_D0, STP_E0, STP_E3: r_acc <= EXT_W'(w_p);
                STP_D1, STP_E1:         r_v1  <= sat_sw(r_acc + EXT_W'(w_p));
                STP_D2: begin
                    r_v2 <= w_v2n;
                    if (i_ctl.solo_hit) r_solo <= r_v1;
                end
                STP_E2:                 r_v2  <= w_v2n;
                STP_E4:                 r_acc <= r_acc + EXT_W'(w_p);
                STP_E5:                 r_x   <= sat_sw(r_acc + EXT_W'(w_p));
                STP_MIX:                o_sample <= w_smp;
                default: ;
            endcase
        end
    end
endmodule

@@ rtl/core/meq_env.sv @@
// ----------------------------------------------------------------------------
// meq_env
// Merge stage: folds both lanes' detector peaks per band and runs the
// attack/release envelope update with its own multiplier.
// ----------------------------------------------------------------------------
module meq_env (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  meq_pkg::t_env_ctl                 i_ctl,
    input  logic        [meq_pkg::SW-1:0]     i_mag_l,
    input  logic        [meq_pkg::SW-1:0]     i_mag_r,
    input  logic signed [meq_pkg::COEF_W-1:0] i_coef,
    input  logic                              i_dyn_wr,
    input  logic        [7:0]                 i_dyn_mask,
    output logic                              o_attack,
    output logic        [meq_pkg::ENV_W-1:0]  o_env
);
    import meq_pkg::*;

    logic [ENV_W-1:0] r_pk  [BAND_COUNT];
    logic [ENV_W-1:0] r_env [BAND_COUNT];

    logic [SW-1:0]        w_mag;
    logic [ENV_W-1:0]     w_pk_new;
    logic [ENV_W-1:0]     w_pk, w_envb;
    logic signed [31:0]   w_diff;
    logic signed [SW-1:0] w_p;
    logic signed [SW:0]   w_n;
    logic [ENV_W-1:0]     w_n_clamp;

    // peak in Q15.16, saturated
    assign w_mag    = (i_mag_l > i_mag_r) ? i_mag_l : i_mag_r;
    assign w_pk_new = (|w_mag[SW-1:23]) ? ENV_MAX : {w_mag[22:0], 8'd0};

    assign w_pk     = r_pk[i_ctl.band];
    assign w_envb   = r_env[i_ctl.band];
    assign o_attack = w_pk > w_envb;
    assign o_env    = w_envb;
    assign w_diff   = $signed({1'b0, w_envb}) - $signed({1'b0, w_pk});

    meq_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (SW'(w_diff)),
        .i_c    (i_coef),
        .i_sh16 (1'b0),
        .o_p    (w_p)
    );

    assign w_n = (SW+1)'($signed({1'b0, w_pk})) + (SW+1)'(w_p);

    always_comb begin
        if (w_n[SW]) w_n_clamp = '0;
        else if (|w_n[SW-1:ENV_W]) w_n_clamp = ENV_MAX;
        else w_n_clamp = w_n[ENV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_peaks) begin
            for (int i = 0; i < BAND_COUNT; i++) r_pk[i] <= '0;
        end else if (i_ctl.peak_upd && (w_pk_new > w_pk)) begin
            r_pk[i_ctl.band] <= w_pk_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BAND_COUNT; i++) r_env[i] <= '0;
        end else if (i_dyn_wr) begin
            // drop envelopes of bands that are no longer tracked
            for (int i = 0; i < BAND_COUNT; i++) begin
                if (!mask_bit(i_dyn_mask, BAND_W'(i))) r_env[i] <= '0;
            end
        end else if (i_ctl.consume) begin
            r_env[i_ctl.band] <= w_n_clamp;
        end
    end
endmodule

@@ rtl/core/multiband_dynamic_svf_equalizer.sv @@
// ----------------------------------------------------------------------------
// multiband_dynamic_svf_equalizer
// Stereo multiband dynamic EQ built from trapezoidal SVF sections.
// ----------------------------------------------------------------------------
// Sequencing: each band walks its 9 filter steps in turn. A step runs as
//   a multiply slot (coefficient read, two multiplier stages, writeback)
//   or is skipped when inactive; the mix runs as one slot, each envelope
//   band runs a slot or is skipped, and the result goes to the output last.
// Throughput: one frame at a time, set by the single multiplier per lane;
//   coefficient writes stay idle; envelope reads go straight to the output.
// Reset: synchronous, active low; clears integrators, envelopes, wet mix and
//   the configuration, sequencer and output-valid registers. The coefficient
//   store is not cleared.
module multiband_dynamic_svf_equalizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    meq_in_if.sink                          i_in,
    meq_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [meq_pkg::CFG_AW-1:0]      i_cfg_idx,
    input  logic [meq_pkg::CFG_DW-1:0]      i_cfg_data
);
    import meq_pkg::*;

    // phases of one multiply slot
    localparam logic [1:0] PH_READ = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BAND_COUNT - 1);

    // configuration
    logic [7:0]        r_dyn, r_mute;
    logic [3:0]        r_solo;
    logic [15:0]       r_tgt, r_wstep;
    logic [WET_W-1:0]  r_wet;

    // sequencer
    t_state            r_state, n_state;
    t_step             r_step, n_step;
    logic [1:0]        r_phase, n_phase;
    logic [BAND_W-1:0] r_band, n_band;

    // coefficient store
    logic signed [COEF_W-1:0] r_coef_mem [COEF_DEPTH];
    logic signed [COEF_W-1:0] r_coef_rd;
    logic [COEF_AW-1:0]       w_rd_addr, w_wr_addr;
    logic [3:0]               w_rd_idx;

    // result staging
    logic                     r_is_frame;
    logic [ENV_W-1:0]         r_env_hold;
    logic                     r_out_valid;
    logic signed [SMP_W-1:0]  r_left_out, r_right_out;
    logic [ENV_W-1:0]         r_env_out;

    logic        w_acc;
    logic        w_frame_acc, w_coef_acc, w_env_acc;
    logic        w_en_b, w_mute_b, w_solo_on, w_solo_hit, w_det, w_active;
    logic        w_consume, w_peak_upd, w_env_consume, w_wet_upd, w_load_out;
    logic        w_attack;
    logic [ENV_W-1:0]         w_env_rd;
    logic signed [COEF_W-1:0] w_wet_c;
    logic signed [SMP_W-1:0]  w_smp_l, w_smp_r;
    logic [SW-1:0]            w_mag_l, w_mag_r;
    t_lane_ctl   w_lane_ctl;
    t_env_ctl    w_env_ctl;

    // ------------------------------------------------------------------
    // Request handshake: take a word only when the sequencer is idle.
    // ------------------------------------------------------------------
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_frame_acc = w_acc && (i_in.req_type == REQ_FRAME);
    assign w_coef_acc  = w_acc && (i_in.req_type == REQ_COEF);
    assign w_env_acc   = w_acc && (i_in.req_type == REQ_ENV);

    // ------------------------------------------------------------------
    // Per-band flags for the band under work
    // ------------------------------------------------------------------
    assign w_en_b     = mask_bit(r_dyn, r_band);
    assign w_mute_b   = mask_bit(r_mute, r_band);
    assign w_solo_on  = (int'(r_solo) < BAND_COUNT);
    assign w_solo_hit = w_solo_on && (int'(r_solo) == int'(r_band));
    assign w_det      = (r_step == STP_D0) || (r_step == STP_D1) || (r_step == STP_D2);
    // detector steps run for tracked or soloed bands, EQ steps unless muted
    assign w_active   = w_det ? (w_en_b || w_solo_hit) : !w_mute_b;

    // mix gain in Q.16: wet_current * 2
    assign w_wet_c = $signed({14'd0, r_wet, 1'b0});

    // ------------------------------------------------------------------
    // Sequencer: state register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STP_D0;
            r_phase <= PH_READ;
            r_band  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_phase <= n_phase;
            r_band  <= n_band;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and strobes. Bands run one after another; each
    // band walks detector steps then EQ steps; then mix, then envelopes.
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_phase       = r_phase;
        n_band        = r_band;
        w_rd_idx      = step_coef(r_step);
        w_consume     = 1'b0;
        w_peak_upd    = 1'b0;
        w_env_consume = 1'b0;
        w_wet_upd     = 1'b0;
        w_load_out    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_frame_acc) begin
                    n_state = ST_BAND;
                    n_band  = '0;
                    n_step  = STP_D0;
                    n_phase = PH_READ;
                end else if (w_env_acc) begin
                    n_state = ST_DONE;
                end
            end
            ST_BAND: begin
                if ((r_phase == PH_READ && !w_active) || r_phase == PH_DONE) begin
                    // advance to the next step or band
                    n_phase = PH_READ;
                    if (r_phase == PH_DONE) begin
                        w_consume  = 1'b1;
                        w_peak_upd = (r_step == STP_D2) && w_en_b;
                    end
                    if (r_step == STP_E5) begin
                        n_step = STP_D0;
                        if (r_band == LAST_BAND) begin
                            n_state = ST_MIX;
                            n_band  = '0;
                        end else begin
                            n_band = r_band + BAND_W'(1);
                        end
                    end else begin
                        n_step = t_step'(r_step + 4'd1);
                    end
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            ST_MIX: begin
                if (r_phase == PH_DONE) begin
                    w_consume = 1'b1;
                    n_state   = ST_ENV;
                    n_band    = '0;
                    n_phase   = PH_READ;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            ST_ENV: begin
                if (r_phase == PH_READ) begin
                    w_rd_idx = w_attack ? CI_ATK : CI_REL;
                end
                if ((r_phase == PH_READ && !w_en_b) || r_phase == PH_DONE) begin
                    w_env_consume = (r_phase == PH_DONE);
                    n_phase       = PH_READ;
                    if (r_band == LAST_BAND) begin
                        n_state   = ST_DONE;
                        n_band    = '0;
                        w_wet_upd = 1'b1;
                    end else begin
                        n_band = r_band + BAND_W'(1);
                    end
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end
            ST_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Coefficient store: write on a coefficient word, read every cycle
    // ------------------------------------------------------------------
    assign w_wr_addr = COEF_AW'(int'(i_in.band_sel) * COEFS_PER_BAND + int'(i_in.coef_sel));
    assign w_rd_addr = COEF_AW'(int'(r_band) * COEFS_PER_BAND + int'(w_rd_idx));

    always_ff @(posedge i_clk) begin
        if (w_coef_acc && (int'(i_in.band_sel) < BAND_COUNT) &&
            (int'(i_in.coef_sel) < COEFS_PER_BAND)) begin
            r_coef_mem[w_wr_addr] <= i_in.coef_value;
        end
        r_coef_rd <= r_coef_mem[w_rd_addr];
    end

    // ------------------------------------------------------------------
    // Lanes: left and right channels run in lockstep
    // ------------------------------------------------------------------
    always_comb begin
        w_lane_ctl.load     = w_frame_acc;
        w_lane_ctl.consume  = w_consume;
        w_lane_ctl.step     = (r_state == ST_MIX) ? STP_MIX : r_step;
        w_lane_ctl.band     = r_band;
        w_lane_ctl.solo_hit = w_solo_hit;
        w_lane_ctl.solo_on  = w_solo_on;
    end

    meq_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_sample (i_in.left_in),
        .i_coef   (r_coef_rd),
        .i_wet_c  (w_wet_c),
        .o_sample (w_smp_l),
        .o_mag    (w_mag_l)
    );

    meq_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_sample (i_in.right_in),
        .i_coef   (r_coef_rd),
        .i_wet_c  (w_wet_c),
        .o_sample (w_smp_r),
        .o_mag    (w_mag_r)
    );

    // ------------------------------------------------------------------
    // Merge stage: peaks of both lanes and the envelopes. While idle it is
    // addressed by the request's band so an envelope read sees its entry.
    // ------------------------------------------------------------------
    always_comb begin
        w_env_ctl.clr_peaks = w_frame_acc;
        w_env_ctl.peak_upd  = w_peak_upd;
        w_env_ctl.consume   = w_env_consume;
        w_env_ctl.band      = (r_state == ST_IDLE) ? BAND_W'(i_in.band_sel) : r_band;
    end

    meq_env u_env (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_env_ctl),
        .i_mag_l    (w_mag_l),
        .i_mag_r    (w_mag_r),
        .i_coef     (r_coef_rd),
        .i_dyn_wr   (i_cfg_we && (i_cfg_idx == CFG_DYN)),
        .i_dyn_mask (i_cfg_data[7:0]),
        .o_attack   (w_attack),
        .o_env      (w_env_rd)
    );

    // ------------------------------------------------------------------
    // Configuration registers and wet ramp
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn   <= '0;
            r_mute  <= '0;
            r_solo  <= 4'd8;
            r_tgt   <= '0;
            r_wstep <= 16'd64;
            r_wet   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DYN:  r_dyn   <= i_cfg_data[7:0];
                    CFG_MUTE: r_mute  <= i_cfg_data[7:0];
                    CFG_SOLO: r_solo  <= i_cfg_data[3:0];
                    // clamp the target to fully wet
                    CFG_TGT:  r_tgt   <= (i_cfg_data > 16'd32768) ? 16'd32768 : i_cfg_data;
                    CFG_STEP: r_wstep <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_wet_upd) begin
                // step toward the target, stop on it
                if (r_wet < WET_W'(r_tgt)) begin
                    if (WET_W'(r_tgt) - r_wet > WET_W'(r_wstep)) r_wet <= r_wet + WET_W'(r_wstep);
                    else r_wet <= WET_W'(r_tgt);
                end else if (r_wet > WET_W'(r_tgt)) begin
                    if (r_wet - WET_W'(r_tgt) > WET_W'(r_wstep)) r_wet <= r_wet - WET_W'(r_wstep);
                    else r_wet <= WET_W'(r_tgt);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result staging and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_is_frame <= (i_in.req_type == REQ_FRAME);
            r_env_hold <= (int'(i_in.band_sel) < BAND_COUNT) ? w_env_rd : '0;
        end
        if (w_load_out) begin
            r_left_out  <= r_is_frame ? w_smp_l : '0;
            r_right_out <= r_is_frame ? w_smp_r : '0;
            r_env_out   <= r_is_frame ? '0 : r_env_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.left_out       = r_left_out;
    assign o_out.right_out      = r_right_out;
    assign o_out.envelope_value = r_env_out;

`ifndef SYNTHESIS
    a_frame_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame_acc |=> (r_state == ST_BAND))
        else $error("frame accepted but band sequence did not start");

    a_coef_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_coef_acc |=> (r_state == ST_IDLE))
        else $error("coefficient write left the idle state");

    a_wet_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wet <= WET_ONE)
        else $error("wet mix above unity");

    a_phase_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_READ) |->
            (r_state == ST_BAND || r_state == ST_MIX || r_state == ST_ENV))
        else $error("multiply slot active outside a processing state");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> r_out_valid)
        else $error("result loaded but output not valid");
`endif

endmodule
